// ----- hdl/grc_pkg.sv -----
// shared types and constants for the horizontal grid ray caster
`default_nettype none
package grc_pkg;

  localparam int PX_W    = 18;
  localparam int COT_W   = 16;
  localparam int HIT_W   = 26;
  localparam int STEP_W  = 4;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 3;
  localparam int DIM_W   = 5;
  localparam int ROW_W   = 16;
  localparam int ROWS    = 16;
  // internal coordinate width, wide enough for the farthest step at any setting
  localparam int COORD_W = 32;
  localparam int FRAC    = 8;

  typedef enum logic [1:0] {
    DIR_FALLING  = 2'd0,
    DIR_RISING   = 2'd1,
    DIR_PARALLEL = 2'd2,
    DIR_UNUSED   = 2'd3
  } ray_dir_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_WALL_0     = 3'd2,
    REG_WALL_1     = 3'd3,
    REG_WALL_2     = 3'd4,
    REG_WALL_3     = 3'd5,
    REG_NONE_6     = 3'd6,
    REG_NONE_7     = 3'd7
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] MAP_SIZE_RESET = 5'd12;

endpackage
`default_nettype wire

// ----- hdl/grid_ray_horizontal_cast.sv -----
// top level of the horizontal grid ray caster pipeline
//
// usage: a request is taken on a rising edge with start high and busy low; busy
// stays low, so a new request may be issued every cycle. each request carries
// the player position, the ray direction class and -1/tan in q8.8.
// the block snaps the ray to the first horizontal grid line, then walks up to
// MAX_DEPTH lines, one pipeline stage per line, testing the wall bitmap.
// the stages are three setup stages (snap, multiply, offset add), one stage per
// line step and the output register, the first loaded at the accepting edge;
// done comes from the output register. throughput is one per cycle.
// each result is shown on hit_x, hit_y, wall_hit and lines_stepped for exactly
// one cycle with done high; the receiver cannot stall, so nothing is held.
// map size and wall bitmap are written through cfg_we/cfg_addr/cfg_data and
// must only change while no request is in flight.
// reset clears all pipeline valid bits, sets the map to 12 by 12 and clears
// every wall bit; nothing is in flight after reset.
`default_nettype none
module grid_ray_horizontal_cast #(
  parameter int MAX_DEPTH  = 8,
  parameter int MAP_DIM    = 16,
  parameter int CELL_SHIFT = 6
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [grc_pkg::PX_W-1:0]             player_x,
  input  wire logic [grc_pkg::PX_W-1:0]             player_y,
  input  wire logic [1:0]                           ray_direction,
  input  wire logic signed [grc_pkg::COT_W-1:0]     neg_cotangent,
  input  wire logic                                 cfg_we,
  input  wire logic [grc_pkg::ADDR_W-1:0]           cfg_addr,
  input  wire logic [grc_pkg::CFG_W-1:0]            cfg_data,
  output logic                                      done,
  output logic signed [grc_pkg::HIT_W-1:0]          hit_x,
  output logic signed [grc_pkg::HIT_W-1:0]          hit_y,
  output logic                                      wall_hit,
  output logic [grc_pkg::STEP_W-1:0]                lines_stepped
);
  import grc_pkg::*;

  localparam int SH     = CELL_SHIFT + FRAC;
  localparam int DIFF_W = SH + 2;
  localparam int PROD_W = DIFF_W + COT_W;
  localparam int XO_W   = COT_W + CELL_SHIFT + 1;
  localparam int DOF_W  = $clog2(MAX_DEPTH + 1);
  localparam logic signed [COORD_W-1:0] CELL = COORD_W'(1) <<< SH;

  // configuration registers
  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [CFG_W-1:0] wall_rows [4];
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [ROWS*ROW_W-1:0] wall_flat;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_SIZE_RESET;
      map_height <= MAP_SIZE_RESET;
      for (int i = 0; i < 4; i++) begin
        wall_rows[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MAP_WIDTH:  map_width    <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height   <= cfg_data[DIM_W-1:0];
        REG_WALL_0:     wall_rows[0] <= cfg_data;
        REG_WALL_1:     wall_rows[1] <= cfg_data;
        REG_WALL_2:     wall_rows[2] <= cfg_data;
        REG_WALL_3:     wall_rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (map_width  < DIM_W'(MAP_DIM)) ? map_width  : DIM_W'(MAP_DIM);
    h_eff = (map_height < DIM_W'(MAP_DIM)) ? map_height : DIM_W'(MAP_DIM);
    wall_flat = {wall_rows[3], wall_rows[2], wall_rows[1], wall_rows[0]};
  end

  assign busy = 1'b0;

  // stage 1: snap to the first horizontal line
  logic                       s1_valid;
  logic [PX_W-1:0]            s1_px;
  logic signed [COORD_W-1:0]  s1_ry;
  logic signed [DIFF_W-1:0]   s1_diff;
  logic signed [COT_W-1:0]    s1_c;
  logic signed [XO_W-1:0]     s1_xo;
  logic                       s1_rising;
  logic                       s1_par;

  logic signed [COORD_W-1:0]  base;
  logic signed [COORD_W-1:0]  py_s;
  logic signed [COORD_W-1:0]  ry_next;
  logic signed [COORD_W-1:0]  diff_full;
  logic signed [XO_W-1:0]     xo_fall;
  logic                       par_in;

  always_comb begin
    py_s    = COORD_W'(player_y);
    base    = COORD_W'({player_y[PX_W-1:SH], {SH{1'b0}}});
    par_in  = !(ray_direction == DIR_FALLING || ray_direction == DIR_RISING);
    xo_fall = XO_W'(neg_cotangent) <<< CELL_SHIFT;
    if (par_in) begin
      ry_next = py_s;
    end else if (ray_direction == DIR_FALLING) begin
      ry_next = base - COORD_W'(1);
    end else begin
      ry_next = base + CELL;
    end
    diff_full = py_s - ry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_px     <= player_x;
    s1_ry     <= ry_next;
    s1_diff   <= DIFF_W'(diff_full);
    s1_c      <= neg_cotangent;
    s1_xo     <= (ray_direction == DIR_FALLING) ? xo_fall : -xo_fall;
    s1_rising <= (ray_direction == DIR_RISING);
    s1_par    <= par_in;
  end

  // stage 2: offset product
  logic                       s2_valid;
  logic [PX_W-1:0]            s2_px;
  logic signed [COORD_W-1:0]  s2_ry;
  logic signed [PROD_W-1:0]   s2_prod;
  logic signed [XO_W-1:0]     s2_xo;
  logic                       s2_rising;
  logic                       s2_par;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_px     <= s1_px;
    s2_ry     <= s1_ry;
    s2_prod   <= PROD_W'(s1_diff) * PROD_W'(s1_c);
    s2_xo     <= s1_xo;
    s2_rising <= s1_rising;
    s2_par    <= s1_par;
  end

  // step stages: index 0 holds the first intersection
  logic                       st_valid  [MAX_DEPTH+1];
  logic signed [COORD_W-1:0]  st_rx     [MAX_DEPTH+1];
  logic signed [COORD_W-1:0]  st_ry     [MAX_DEPTH+1];
  logic signed [XO_W-1:0]     st_xo     [MAX_DEPTH+1];
  logic                       st_rising [MAX_DEPTH+1];
  logic                       st_stop   [MAX_DEPTH+1];
  logic                       st_hit    [MAX_DEPTH+1];
  logic [DOF_W-1:0]           st_dof    [MAX_DEPTH+1];

  logic signed [PROD_W-1:0]   prod_sh;

  always_comb begin
    prod_sh = s2_prod >>> FRAC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= s2_valid;
    end
    st_rx[0]     <= COORD_W'(s2_px) + COORD_W'(prod_sh);
    st_ry[0]     <= s2_ry;
    st_xo[0]     <= s2_xo;
    st_rising[0] <= s2_rising;
    st_stop[0]   <= s2_par;
    st_hit[0]    <= 1'b0;
    st_dof[0]    <= '0;
  end

  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_step
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      in_map;
    logic                      wall;

    always_comb begin
      col    = st_rx[k] >>> SH;
      row    = st_ry[k] >>> SH;
      in_map = (col >= 0) && (row >= 0)
            && (col < COORD_W'(w_eff)) && (row < COORD_W'(h_eff));
      wall   = in_map && wall_flat[{row[3:0], col[3:0]}];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
      st_xo[k+1]     <= st_xo[k];
      st_rising[k+1] <= st_rising[k];
      if (st_stop[k]) begin
        st_rx[k+1]   <= st_rx[k];
        st_ry[k+1]   <= st_ry[k];
        st_stop[k+1] <= 1'b1;
        st_hit[k+1]  <= st_hit[k];
        st_dof[k+1]  <= st_dof[k];
      end else if (wall) begin
        st_rx[k+1]   <= st_rx[k];
        st_ry[k+1]   <= st_ry[k];
        st_stop[k+1] <= 1'b1;
        st_hit[k+1]  <= 1'b1;
        st_dof[k+1]  <= st_dof[k];
      end else begin
        st_rx[k+1]   <= st_rx[k] + COORD_W'(st_xo[k]);
        st_ry[k+1]   <= st_rising[k] ? (st_ry[k] + CELL) : (st_ry[k] - CELL);
        st_stop[k+1] <= 1'b0;
        st_hit[k+1]  <= 1'b0;
        st_dof[k+1]  <= st_dof[k] + DOF_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_valid[MAX_DEPTH];
    end
    hit_x         <= st_rx[MAX_DEPTH][HIT_W-1:0];
    hit_y         <= st_ry[MAX_DEPTH][HIT_W-1:0];
    wall_hit      <= st_hit[MAX_DEPTH];
    lines_stepped <= STEP_W'(st_dof[MAX_DEPTH]);
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the horizontal grid ray caster
module tb_top;
  import grc_pkg::*;

  localparam int DEPTH          = 8;
  localparam int LATENCY        = DEPTH + 4;
  localparam int CELL_BITS      = 6 + FRAC;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 8;
  localparam int RAYS_PER_PHASE = 250;

  typedef struct packed {
    logic [HIT_W-1:0]  x;
    logic [HIT_W-1:0]  y;
    logic              hit;
    logic [STEP_W-1:0] steps;
  } ray_hit_t;

  class hit_scoreboard;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [CFG_W-1:0] walls [4];
    ray_hit_t         expected_hits [$];
    int               mismatches;
    int               wall_stops;
    int               full_depth;

    function new();
      width  = MAP_SIZE_RESET;
      height = MAP_SIZE_RESET;
      foreach (walls[i]) walls[i] = '0;
      mismatches = 0;
      wall_stops = 0;
      full_depth = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MAP_WIDTH:  width = val[DIM_W-1:0];
        REG_MAP_HEIGHT: height = val[DIM_W-1:0];
        REG_WALL_0:     walls[0] = val;
        REG_WALL_1:     walls[1] = val;
        REG_WALL_2:     walls[2] = val;
        REG_WALL_3:     walls[3] = val;
        default:        ;
      endcase
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    // cells outside the effective map never hold a wall
    function bit wall_at(longint col, longint row);
      longint w;
      longint h;
      logic [CFG_W-1:0] bits;
      w = (width < ROWS) ? longint'(width) : ROWS;
      h = (height < ROWS) ? longint'(height) : ROWS;
      if (col < 0 || row < 0 || col >= w || row >= h) return 1'b0;
      bits = walls[int'(row >> 2)];
      return bits[int'((row % 4) * ROW_W + col)];
    endfunction

    function ray_hit_t cast_ray(logic [PX_W-1:0] px, logic [PX_W-1:0] py, ray_dir_t dir,
                                logic signed [COT_W-1:0] cot);
      longint rx;
      longint ry;
      longint py_l;
      longint c;
      longint xo;
      longint yo;
      longint base;
      int lines;
      ray_hit_t r;
      rx = longint'(px);
      py_l = longint'(py);
      ry = py_l;
      c = longint'(cot);
      lines = 0;
      r.hit = 1'b0;
      if (dir == DIR_FALLING || dir == DIR_RISING) begin
        base = (py_l >>> CELL_BITS) <<< CELL_BITS;
        if (dir == DIR_FALLING) begin
          // one lsb below the line stands for the epsilon
          ry = base - 1;
          yo = -(longint'(1) <<< CELL_BITS);
          xo = c * 64;
        end else begin
          ry = base + (longint'(1) <<< CELL_BITS);
          yo = longint'(1) <<< CELL_BITS;
          xo = -c * 64;
        end
        rx = rx + (((py_l - ry) * c) >>> FRAC);
        while (lines < DEPTH && !r.hit) begin
          if (wall_at(rx >>> CELL_BITS, ry >>> CELL_BITS)) begin
            r.hit = 1'b1;
          end else begin
            rx += xo;
            ry += yo;
            lines++;
          end
        end
      end
      r.x = rx[HIT_W-1:0];
      r.y = ry[HIT_W-1:0];
      r.steps = lines[STEP_W-1:0];
      return r;
    endfunction

    function void note_request(logic [PX_W-1:0] px, logic [PX_W-1:0] py, ray_dir_t dir,
                               logic signed [COT_W-1:0] cot);
      ray_hit_t r;
      r = cast_ray(px, py, dir, cot);
      if (r.hit) wall_stops++;
      else if (r.steps == DEPTH) full_depth++;
      expected_hits.push_back(r);
    endfunction

    function void check_result(logic [HIT_W-1:0] hx, logic [HIT_W-1:0] hy, logic hit,
                               logic [STEP_W-1:0] steps);
      ray_hit_t e;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result x=%0d y=%0d hit=%0b steps=%0d with no request pending",
                   $signed(hx), $signed(hy), hit, steps);
        return;
      end
      e = expected_hits.pop_front();
      if (hx !== e.x || hy !== e.y || hit !== e.hit || steps !== e.steps) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d hit=%0b steps=%0d, got x=%0d y=%0d hit=%0b steps=%0d",
                   $signed(e.x), $signed(e.y), e.hit, e.steps,
                   $signed(hx), $signed(hy), hit, steps);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [PX_W-1:0]         player_x = '0;
  logic [PX_W-1:0]         player_y = '0;
  logic [1:0]              ray_direction = DIR_FALLING;
  logic signed [COT_W-1:0] neg_cotangent = '0;
  logic                    cfg_we = 1'b0;
  logic [ADDR_W-1:0]       cfg_addr = REG_MAP_WIDTH;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    busy;
  logic                    done;
  logic signed [HIT_W-1:0] hit_x;
  logic signed [HIT_W-1:0] hit_y;
  logic                    wall_hit;
  logic [STEP_W-1:0]       lines_stepped;

  hit_scoreboard sb = new();
  int idle_cycles = 0;
  int quiet_run = 0;
  int rays_sent = 0;
  int map_settings = 0;

  always #5 clk = ~clk;

  grid_ray_horizontal_cast dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .player_x(player_x), .player_y(player_y), .ray_direction(ray_direction),
    .neg_cotangent(neg_cotangent),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .done(done), .hit_x(hit_x), .hit_y(hit_y), .wall_hit(wall_hit),
    .lines_stepped(lines_stepped)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(hit_x, hit_y, wall_hit, lines_stepped);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic cast_one(logic [PX_W-1:0] px, logic [PX_W-1:0] py, ray_dir_t dir,
                          logic signed [COT_W-1:0] cot);
    player_x <= px;
    player_y <= py;
    ray_direction <= dir;
    neg_cotangent <= cot;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(px, py, dir, cot);
    rays_sent++;
  endtask

  // mostly back-to-back, some short gaps, a few long ones, and quiet bursts
  function automatic int next_gap();
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    case ($urandom_range(0, 19))
      0:          begin quiet_run = $urandom_range(20, 80); return 0; end
      1, 2:       return $urandom_range(8, 40);
      3, 4, 5, 6: return $urandom_range(1, 3);
      default:    return 0;
    endcase
  endfunction

  task automatic sender_gap();
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every request retire so the map can change safely
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // leaves the write enable high; callers drop it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_map(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [CFG_W-1:0] r0,
                          logic [CFG_W-1:0] r1, logic [CFG_W-1:0] r2, logic [CFG_W-1:0] r3);
    drain();
    write_reg(REG_MAP_WIDTH, CFG_W'(w));
    write_reg(REG_MAP_HEIGHT, CFG_W'(h));
    write_reg(REG_WALL_0, r0);
    write_reg(REG_WALL_1, r1);
    write_reg(REG_WALL_2, r2);
    write_reg(REG_WALL_3, r3);
    cfg_we <= 1'b0;
    map_settings++;
  endtask

  function automatic logic [PX_W-1:0] cell_mid(int k);
    return PX_W'((k << CELL_BITS) + (1 << (CELL_BITS - 1)));
  endfunction

  function automatic logic [CFG_W-1:0] random_walls(int mode);
    logic [CFG_W-1:0] a;
    logic [CFG_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case (mode)
      0, 1:    return a & b & {$urandom, $urandom};
      2:       return a & b;
      3:       return a;
      default: return '0;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_size();
    case ($urandom_range(0, 11))
      0:          return '0;
      1:          return DIM_W'(1);
      2:          return '1;
      3, 4, 5, 6: return DIM_W'(ROWS);
      default:    return DIM_W'($urandom_range(2, 15));
    endcase
  endfunction

  function automatic ray_dir_t random_dir();
    case ($urandom_range(0, 19))
      0:       return DIR_PARALLEL;
      1:       return DIR_UNUSED;
      default: return $urandom_range(0, 1) ? DIR_RISING : DIR_FALLING;
    endcase
  endfunction

  // gentle slopes keep the ray inside the map long enough to find walls
  function automatic logic signed [COT_W-1:0] random_cot();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 1024)) - 512;
      4, 5, 6:    v = int'($urandom_range(0, 8192)) - 4096;
      7:          v = $urandom_range(0, 1) ? 32767 : -32768;
      default:    v = $urandom;
    endcase
    return v[COT_W-1:0];
  endfunction

  // positions near grid lines test the floor at cell edges
  function automatic logic [PX_W-1:0] random_pos();
    int v;
    if ($urandom_range(0, 4) == 0) begin
      v = (int'($urandom_range(0, 16)) << CELL_BITS) + int'($urandom_range(0, 6)) - 3;
      return v[PX_W-1:0];
    end
    return PX_W'($urandom);
  endfunction

  initial begin
    int mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset map: 12 by 12, no walls
    cast_one('1, '0, DIR_PARALLEL, 16'sh7fff);
    cast_one('0, '1, DIR_UNUSED, 16'sh8000);
    cast_one('0, '0, DIR_FALLING, '0);
    cast_one('1, '1, DIR_RISING, '0);
    cast_one(cell_mid(8), cell_mid(8), DIR_FALLING, 16'sh7fff);
    cast_one(cell_mid(8), cell_mid(8), DIR_RISING, 16'sh8000);
    cast_one(cell_mid(3), cell_mid(5), DIR_FALLING, 16'sh0100);
    cast_one(cell_mid(3), cell_mid(5), DIR_RISING, 16'shff00);

    // solid walls: the first two rays stop at the first line, the third misses the map
    load_map(DIM_W'(ROWS), DIM_W'(ROWS), '1, '1, '1, '1);
    cast_one(cell_mid(7), cell_mid(7), DIR_FALLING, '0);
    cast_one(cell_mid(7), cell_mid(7), DIR_RISING, '0);
    cast_one('0, cell_mid(2), DIR_RISING, 16'sh0001);

    // zero width or height leaves nothing in bounds
    load_map('0, DIM_W'(ROWS), '1, '1, '1, '1);
    cast_one(cell_mid(7), cell_mid(7), DIR_FALLING, '0);
    load_map(DIM_W'(ROWS), '0, '1, '1, '1, '1);
    cast_one(cell_mid(7), cell_mid(7), DIR_RISING, '0);

    // oversized dimension clamps; only the two corner cells are walls
    load_map('1, '1, 64'h1, '0, '0, 64'h8000_0000_0000_0000);
    cast_one(cell_mid(15), cell_mid(8), DIR_RISING, '0);
    cast_one(cell_mid(0), cell_mid(7), DIR_FALLING, '0);
    cast_one(cell_mid(0), cell_mid(0), DIR_FALLING, '0);

    // writes past the last register must change nothing
    drain();
    write_reg(REG_NONE_6, '1);
    write_reg(REG_NONE_7, '0);
    cfg_we <= 1'b0;
    cast_one(cell_mid(15), cell_mid(8), DIR_RISING, '0);
    cast_one(cell_mid(0), cell_mid(7), DIR_FALLING, '0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = (p == 0) ? 0 : $urandom_range(0, 4);
      if (p == 0)
        load_map(DIM_W'(ROWS), DIM_W'(ROWS), random_walls(mode), random_walls(mode),
                 random_walls(mode), random_walls(mode));
      else
        load_map(random_size(), random_size(), random_walls(mode), random_walls(mode),
                 random_walls(mode), random_walls(mode));
      for (int i = 0; i < RAYS_PER_PHASE; i++) begin
        cast_one(random_pos(), random_pos(), random_dir(), random_cot());
        sender_gap();
      end
    end

    drain();
    $display("cast %0d rays over %0d map settings: %0d stopped by a wall, %0d ran full depth",
             rays_sent, map_settings, sb.wall_stops, sb.full_depth);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
